// ===== hw/rtl/sagp_pkg.sv =====
// ----------------------------------------------------------------------------
// sagp_pkg
// Shared types, register indexes and constants of the spatial gain/pan core.
// ----------------------------------------------------------------------------
`default_nettype none

package sagp_pkg;

	localparam int IN_W       = 136;
	localparam int OUT_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int FIFO_DEPTH = 4;
	localparam int ONE_Q14    = 16384;

	localparam logic [16:0] UNITY = 17'd65536;

	localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FORWARD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EFFECTS = 3'd6;

	localparam logic [47:0] FORWARD_RESET = 48'd211106232532992;
	localparam logic [47:0] UP_RESET      = 48'd1073741824;

	// unit right vector for the reset orientation
	localparam logic signed [15:0] RV_RESET_NX = 16'sd16384;

	typedef struct packed {
		logic               deg;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
	} rvec_t;

	typedef struct packed {
		logic signed [25:0] dx;
		logic signed [25:0] dy;
		logic signed [25:0] dz;
		logic        [22:0] near_dist;
		logic        [22:0] far_dist;
		logic        [16:0] ev;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               pzero;
	} fe_t;

	function automatic logic [16:0] sat_unity(input logic [16:0] v);
		return (v > UNITY) ? UNITY : v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spatial_audio_gain_pan_core.sv =====
// ----------------------------------------------------------------------------
// spatial_audio_gain_pan_core
// Distance attenuation and stereo pan levels for one sound emitter per item.
// ----------------------------------------------------------------------------
// One emitter is accepted per clock unless the right vector unit is busy or the
// queue is full; its result then passes the arithmetic pipeline (one bit per
// stage for the 25-bit distance root, the 15-bit pan quotient and the 16-bit
// gain quotient). A write to listener_forward or listener_up starts the right
// vector unit, which holds the input side off while it runs its shared 32x32
// multiplier, the root and the three divides. Other register writes take
// effect at once.
`default_nettype none

module spatial_audio_gain_pan_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [sagp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sagp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// emitter_x, emitter_y, emitter_z, near_distance, far_distance,
	// emitter_volume, one zero pad bit
	input  wire logic [sagp_pkg::IN_W-1:0]        s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// channel_volume, pan_left, pan_right
	output logic [sagp_pkg::OUT_W-1:0]            m_axis_tdata
);
	import sagp_pkg::*;

	logic [23:0] pos_x_q, pos_y_q, pos_z_q;
	logic [47:0] forward_q, up_q;
	logic [16:0] master_q, effects_q;
	logic        rv_start;
	logic        rv_busy;
	rvec_t       rv;
	fe_t         fe_wr, fe_rd;
	logic        fe_push, fe_pop, fe_full, fe_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			pos_z_q   <= '0;
			forward_q <= FORWARD_RESET;
			up_q      <= UP_RESET;
			master_q  <= UNITY;
			effects_q <= UNITY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POS_X:   pos_x_q   <= cfg_data[23:0];
				REG_POS_Y:   pos_y_q   <= cfg_data[23:0];
				REG_POS_Z:   pos_z_q   <= cfg_data[23:0];
				REG_FORWARD: forward_q <= cfg_data;
				REG_UP:      up_q      <= cfg_data;
				REG_MASTER:  master_q  <= sat_unity(cfg_data[16:0]);
				REG_EFFECTS: effects_q <= sat_unity(cfg_data[16:0]);
				default:     ;
			endcase
		end
	end

	assign rv_start = cfg_we && (cfg_index == REG_FORWARD || cfg_index == REG_UP);

	sagp_rvec u_rvec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rv_start),
		.fwd    (forward_q),
		.up     (up_q),
		.busy   (rv_busy),
		.rv     (rv)
	);

	sagp_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.pos_x         (pos_x_q),
		.pos_y         (pos_y_q),
		.pos_z         (pos_z_q),
		.rv            (rv),
		.rv_busy       (rv_busy),
		.fifo_full     (fe_full),
		.push          (fe_push),
		.entry         (fe_wr)
	);

	sagp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fe_push),
		.wr_data (fe_wr),
		.pop     (fe_pop),
		.rd_data (fe_rd),
		.full    (fe_full),
		.empty   (fe_empty)
	);

	sagp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.entry         (fe_rd),
		.empty         (fe_empty),
		.pop           (fe_pop),
		.master        (master_q),
		.effects       (effects_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/sagp_rvec.sv =====
// ----------------------------------------------------------------------------
// sagp_rvec
// Sequential unit: unit right vector (forward x up, normalized) in Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

module sagp_rvec (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [47:0]   fwd,
	input  wire logic [47:0]   up,
	output logic               busy,
	output sagp_pkg::rvec_t    rv
);
	import sagp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	localparam int MUL_LAST  = 8;
	localparam int SQRT_LAST = 31;
	localparam int DIV_LAST  = 45;

	logic [1:0]         state_q;
	logic [5:0]         cnt_q;
	logic [1:0]         comp_q;
	logic signed [32:0] t_q;
	logic signed [32:0] r_q [0:2];
	logic [63:0]        sum_q;
	logic [63:0]        rad_q;
	logic [33:0]        rem_q;
	logic [31:0]        root_q;
	logic [45:0]        dv_q;
	logic [31:0]        drem_q;
	logic [14:0]        quo_q;
	logic               neg_q;
	rvec_t              rv_q;

	logic signed [32:0] opa, opb;
	logic [31:0]        ma, mb;
	logic [63:0]        prod;
	logic signed [32:0] sprod;
	logic [35:0]        sq_rem, sq_trial;
	logic               sq_ge;
	logic [33:0]        sq_rem_n;
	logic [31:0]        sq_root_n;
	logic [32:0]        dv_t;
	logic               dv_ge;
	logic [31:0]        drem_n;
	logic [14:0]        quo_n;
	logic signed [15:0] ncomp;

	function automatic logic [31:0] mag32(input logic signed [32:0] a);
		logic [32:0] n;
		n = a[32] ? (~a + 33'd1) : a;
		return n[31:0];
	endfunction

	function automatic logic signed [32:0] sx16(input logic [15:0] a);
		return {{17{a[15]}}, a};
	endfunction

	always_comb begin
		opa = '0;
		opb = '0;
		unique case (cnt_q)
			6'd0: begin opa = sx16(fwd[31:16]); opb = sx16(up[47:32]); end
			6'd1: begin opa = sx16(fwd[47:32]); opb = sx16(up[31:16]); end
			6'd2: begin opa = sx16(fwd[47:32]); opb = sx16(up[15:0]);  end
			6'd3: begin opa = sx16(fwd[15:0]);  opb = sx16(up[47:32]); end
			6'd4: begin opa = sx16(fwd[15:0]);  opb = sx16(up[31:16]); end
			6'd5: begin opa = sx16(fwd[31:16]); opb = sx16(up[15:0]);  end
			6'd6: begin opa = r_q[0]; opb = r_q[0]; end
			6'd7: begin opa = r_q[1]; opb = r_q[1]; end
			6'd8: begin opa = r_q[2]; opb = r_q[2]; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	assign ma    = mag32(opa);
	assign mb    = mag32(opb);
	assign prod  = {32'd0, ma} * {32'd0, mb};
	assign sprod = (opa[32] ^ opb[32]) ? -$signed(prod[32:0]) : $signed(prod[32:0]);

	// one root bit per cycle
	assign sq_rem    = {rem_q, rad_q[63:62]};
	assign sq_trial  = {2'b00, root_q, 2'b01};
	assign sq_ge     = (sq_rem >= sq_trial);
	assign sq_rem_n  = sq_ge ? 34'(sq_rem - sq_trial) : sq_rem[33:0];
	assign sq_root_n = {root_q[30:0], sq_ge};

	// one quotient bit per cycle
	assign dv_t   = {drem_q, dv_q[45]};
	assign dv_ge  = (dv_t >= {1'b0, root_q});
	assign drem_n = dv_ge ? 32'(dv_t - {1'b0, root_q}) : dv_t[31:0];
	assign quo_n  = {quo_q[13:0], dv_ge};
	assign ncomp  = neg_q ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
			rv_q    <= '{deg: 1'b0, nx: RV_RESET_NX, ny: 16'sd0, nz: 16'sd0};
		end else if (start) begin
			state_q <= ST_MUL;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
				end
				ST_MUL: begin
					if (cnt_q == 6'd0 || cnt_q == 6'd2 || cnt_q == 6'd4) begin
						t_q <= sprod;
					end else if (cnt_q == 6'd1) begin
						r_q[0] <= t_q - sprod;
					end else if (cnt_q == 6'd3) begin
						r_q[1] <= t_q - sprod;
					end else if (cnt_q == 6'd5) begin
						r_q[2] <= t_q - sprod;
					end else if (cnt_q == 6'd6) begin
						sum_q <= prod;
					end else begin
						sum_q <= sum_q + prod;
					end
					if (cnt_q == 6'(MUL_LAST)) begin
						state_q <= ST_SQRT;
						cnt_q   <= '0;
						rad_q   <= sum_q + prod;
						rem_q   <= '0;
						root_q  <= '0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_SQRT: begin
					rad_q  <= {rad_q[61:0], 2'b00};
					rem_q  <= sq_rem_n;
					root_q <= sq_root_n;
					if (cnt_q == 6'(SQRT_LAST)) begin
						cnt_q <= '0;
						if (sq_root_n == 32'd0) begin
							state_q <= ST_IDLE;
							rv_q    <= '{deg: 1'b1, nx: 16'sd0, ny: 16'sd0, nz: 16'sd0};
						end else begin
							state_q <= ST_DIV;
							comp_q  <= '0;
							dv_q    <= {mag32(r_q[0]), 14'd0};
							neg_q   <= r_q[0][32];
							drem_q  <= '0;
							quo_q   <= '0;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_DIV: begin
					dv_q   <= {dv_q[44:0], 1'b0};
					drem_q <= drem_n;
					quo_q  <= quo_n;
					if (cnt_q == 6'(DIV_LAST)) begin
						cnt_q <= '0;
						unique case (comp_q)
							2'd0:    rv_q.nx <= ncomp;
							2'd1:    rv_q.ny <= ncomp;
							default: rv_q.nz <= ncomp;
						endcase
						if (comp_q == 2'd2) begin
							state_q  <= ST_IDLE;
							rv_q.deg <= 1'b0;
						end else begin
							comp_q <= comp_q + 2'd1;
							dv_q   <= {mag32(r_q[comp_q + 2'd1]), 14'd0};
							neg_q  <= r_q[comp_q + 2'd1][32];
							drem_q <= '0;
							quo_q  <= '0;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign rv   = rv_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sagp_front.sv =====
// ----------------------------------------------------------------------------
// sagp_front
// Input side: unpacks an emitter, forms the listener offset and pan flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sagp_front (
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [sagp_pkg::IN_W-1:0] s_axis_tdata,
	input  wire logic [23:0]               pos_x,
	input  wire logic [23:0]               pos_y,
	input  wire logic [23:0]               pos_z,
	input  wire sagp_pkg::rvec_t           rv,
	input  wire logic                      rv_busy,
	input  wire logic                      fifo_full,
	output logic                           push,
	output sagp_pkg::fe_t                  entry
);
	import sagp_pkg::*;

	logic [23:0] ex, ey, ez;
	logic [22:0] nr, fr;

	assign ex = s_axis_tdata[23:0];
	assign ey = s_axis_tdata[47:24];
	assign ez = s_axis_tdata[71:48];
	assign nr = s_axis_tdata[94:72];
	assign fr = s_axis_tdata[117:95];

	assign s_axis_tready = !rv_busy && !fifo_full;
	assign push          = s_axis_tvalid && s_axis_tready;

	always_comb begin
		entry.dx        = $signed({{2{ex[23]}}, ex}) - $signed({{2{pos_x[23]}}, pos_x});
		entry.dy        = $signed({{2{ey[23]}}, ey}) - $signed({{2{pos_y[23]}}, pos_y});
		entry.dz        = $signed({{2{ez[23]}}, ez}) - $signed({{2{pos_z[23]}}, pos_z});
		entry.near_dist = nr;
		entry.far_dist  = fr;
		entry.ev        = sat_unity(s_axis_tdata[134:118]);
		entry.nx        = rv.nx;
		entry.ny        = rv.ny;
		entry.nz        = rv.nz;
		// centered pan for a degenerate right vector or zero far distance
		entry.pzero     = rv.deg || (fr == 23'd0);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sagp_fifo.sv =====
// ----------------------------------------------------------------------------
// sagp_fifo
// Short queue between the input side and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module sagp_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sagp_pkg::fe_t wr_data,
	input  wire logic          pop,
	output sagp_pkg::fe_t      rd_data,
	output logic               full,
	output logic               empty
);
	import sagp_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	fe_t           mem_q [0:FIFO_DEPTH-1];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PW'(1);
			if (pop)  rp_q <= rp_q + PW'(1);
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rd_data = mem_q[rp_q];
	assign full    = (count_q == CW'(FIFO_DEPTH));
	assign empty   = (count_q == '0);

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== hw/rtl/sagp_back.sv =====
// ----------------------------------------------------------------------------
// sagp_back
// Arithmetic pipeline: distance root, gain divide, pan divide, volume product.
// ----------------------------------------------------------------------------
`default_nettype none

module sagp_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire sagp_pkg::fe_t              entry,
	input  wire logic                       empty,
	output logic                            pop,
	input  wire logic [16:0]                master,
	input  wire logic [16:0]                effects,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output logic [sagp_pkg::OUT_W-1:0]      m_axis_tdata
);
	import sagp_pkg::*;

	localparam int SQ_STEPS   = 25;
	localparam int PAN_STEPS  = 15;
	localparam int GAIN_STEPS = 16;
	localparam int GSET       = SQ_STEPS + 1;
	localparam int LAST       = GSET + GAIN_STEPS;

	typedef struct packed {
		logic        [49:0] rad;
		logic        [26:0] rem;
		logic        [24:0] root;
		logic        [39:0] pmag;
		logic        [14:0] pq;
		logic               pneg;
		logic               psat;
		logic               pzero;
		logic        [22:0] near_dist;
		logic        [22:0] far_dist;
		logic        [16:0] v2h;
		logic               gzero;
		logic               gunity;
		logic        [22:0] grem;
		logic        [22:0] gd;
		logic        [15:0] gq;
		logic signed [15:0] pan;
	} bk_t;

	function automatic bk_t sq_step(input bk_t a);
		logic [28:0] remn, trial;
		bk_t r;
		r     = a;
		remn  = {a.rem, a.rad[49:48]};
		trial = {2'b00, a.root, 2'b01};
		if (remn >= trial) begin
			r.rem  = 27'(remn - trial);
			r.root = {a.root[23:0], 1'b1};
		end else begin
			r.rem  = remn[26:0];
			r.root = {a.root[23:0], 1'b0};
		end
		r.rad = {a.rad[47:0], 2'b00};
		return r;
	endfunction

	function automatic bk_t pan_step(input bk_t a, input int sh);
		logic [39:0] dsh;
		bk_t r;
		r   = a;
		dsh = {17'd0, a.far_dist} << sh;
		if (a.pmag >= dsh) begin
			r.pmag   = a.pmag - dsh;
			r.pq[sh] = 1'b1;
		end
		return r;
	endfunction

	function automatic bk_t gain_setup(input bk_t a);
		logic [14:0] mag;
		bk_t r;
		r        = a;
		r.gzero  = 1'b0;
		r.gunity = 1'b0;
		r.gq     = '0;
		r.grem   = a.far_dist - a.root[22:0];
		r.gd     = a.far_dist - a.near_dist;
		if (a.root > {2'b00, a.far_dist}) begin
			r.gzero = 1'b1;
		end else if (a.root <= {2'b00, a.near_dist}) begin
			r.gunity = 1'b1;
		end
		if (a.psat || a.pq > 15'(ONE_Q14)) begin
			mag = 15'(ONE_Q14);
		end else begin
			mag = a.pq;
		end
		if (a.pzero) begin
			r.pan = '0;
		end else if (a.pneg) begin
			r.pan = -$signed({1'b0, mag});
		end else begin
			r.pan = $signed({1'b0, mag});
		end
		return r;
	endfunction

	function automatic bk_t gain_step(input bk_t a);
		logic [23:0] t;
		bk_t r;
		r = a;
		t = {a.grem, 1'b0};
		if (t >= {1'b0, a.gd}) begin
			r.grem = 23'(t - {1'b0, a.gd});
			r.gq   = {a.gq[14:0], 1'b1};
		end else begin
			r.grem = t[22:0];
			r.gq   = {a.gq[14:0], 1'b0};
		end
		return r;
	endfunction

	logic               adv;
	logic               vld_s1;
	logic        [48:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [41:0] pdx_s1, pdy_s1, pdz_s1;
	logic        [33:0] v1_s1;
	logic        [22:0] near_s1, far_s1;
	logic               pzero_s1;
	logic        [LAST:0] vld_s;
	bk_t                pipe_s [0:LAST];
	bk_t                st0;
	logic signed [42:0] dot;
	logic        [42:0] dot_mag;
	logic        [33:0] v2;
	logic               m_valid_q;
	logic        [7:0]  chan_q, left_q, right_q;
	logic        [16:0] gain;
	logic        [33:0] v3;
	logic        [15:0] lm, rm;
	logic        [23:0] lprod, rprod;

	function automatic logic [24:0] mag25(input logic signed [25:0] a);
		logic [25:0] n;
		n = a[25] ? (~a + 26'd1) : a;
		return n[24:0];
	endfunction

	assign adv = !m_valid_q || m_axis_tready;
	assign pop = adv && !empty;

	// squares, dot terms and first volume product
	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s1   <= {24'd0, mag25(entry.dx)} * {24'd0, mag25(entry.dx)};
			sqy_s1   <= {24'd0, mag25(entry.dy)} * {24'd0, mag25(entry.dy)};
			sqz_s1   <= {24'd0, mag25(entry.dz)} * {24'd0, mag25(entry.dz)};
			pdx_s1   <= entry.dx * entry.nx;
			pdy_s1   <= entry.dy * entry.ny;
			pdz_s1   <= entry.dz * entry.nz;
			v1_s1    <= {17'd0, entry.ev} * {17'd0, effects};
			near_s1  <= entry.near_dist;
			far_s1   <= entry.far_dist;
			pzero_s1 <= entry.pzero;
		end
	end

	assign dot     = 43'(pdx_s1) + 43'(pdy_s1) + 43'(pdz_s1);
	assign dot_mag = dot[42] ? 43'(-dot) : 43'(dot);
	assign v2      = {17'd0, v1_s1[32:16]} * {17'd0, master};

	always_comb begin
		st0           = '0;
		st0.rad       = {1'b0, sqx_s1} + {1'b0, sqy_s1} + {1'b0, sqz_s1};
		st0.pmag      = dot_mag[39:0];
		st0.pneg      = dot[42];
		st0.psat      = (dot_mag[39:0] >= {2'b00, far_s1, 15'd0});
		st0.pzero     = pzero_s1;
		st0.near_dist = near_s1;
		st0.far_dist  = far_s1;
		st0.v2h       = v2[32:16];
	end

	always_ff @(posedge clk) begin
		if (adv) pipe_s[0] <= st0;
	end

	for (genvar k = 1; k <= LAST; k++) begin : g_stage
		bk_t nxt;
		always_comb begin
			nxt = pipe_s[k-1];
			if (k <= SQ_STEPS)  nxt = sq_step(nxt);
			if (k <= PAN_STEPS) nxt = pan_step(nxt, PAN_STEPS - k);
			if (k == GSET)      nxt = gain_setup(nxt);
			if (k > GSET)       nxt = gain_step(nxt);
		end
		always_ff @(posedge clk) begin
			if (adv) pipe_s[k] <= nxt;
		end
	end

	always_comb begin
		if (pipe_s[LAST].gzero) begin
			gain = '0;
		end else if (pipe_s[LAST].gunity) begin
			gain = UNITY;
		end else begin
			gain = {1'b0, pipe_s[LAST].gq};
		end
		v3    = {17'd0, pipe_s[LAST].v2h} * {17'd0, gain};
		lm    = 16'(ONE_Q14) - $unsigned(pipe_s[LAST].pan);
		rm    = 16'(ONE_Q14) + $unsigned(pipe_s[LAST].pan);
		lprod = {8'd0, lm} * 24'd255;
		rprod = {8'd0, rm} * 24'd255;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s     <= '0;
			m_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= pop;
			vld_s     <= {vld_s[LAST-1:0], vld_s1};
			m_valid_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chan_q  <= v3[32:25];
			left_q  <= lprod[22:15];
			right_q <= rprod[22:15];
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {right_q, left_q, chan_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (chan_q <= 8'd128))
		else $error("channel volume above full scale");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (({1'b0, left_q} + {1'b0, right_q}) <= 9'd255))
		else $error("pan levels sum above full scale");

endmodule

`default_nettype wire

// ===== tb/sv/tb_spatial_audio_gain_pan_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spatial_audio_gain_pan_core
// Streams emitter updates through the gain/pan core under several listener
// setups and random stalls. Each result is checked against a fixed expected
// value or a local model.
`default_nettype none

module tb_spatial_audio_gain_pan_core;

	import sagp_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int NUM_SETUPS  = 6;
	localparam int RAND_ITEMS  = 950;

	typedef struct {
		logic signed [23:0] ex;
		logic signed [23:0] ey;
		logic signed [23:0] ez;
		logic        [22:0] near_d;
		logic        [22:0] far_d;
		logic        [16:0] vol;
		bit                 known;
		logic        [23:0] levels;   // right, left, channel volume
	} emitter_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;

	// listener copy used by the level model
	logic [23:0] lis_x, lis_y, lis_z;
	logic [47:0] lis_fwd, lis_up;
	logic [16:0] lis_master, lis_effects;

	logic [23:0] level_queue[$];
	int          errors;
	int          results_seen;
	int          snd_idle;
	int          rcv_idle;
	int          hold_req;
	int          stall_cnt;

	spatial_audio_gain_pan_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint unsigned int_root(input longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned clip_unity(input logic [16:0] v);
		return (v > 17'd65536) ? 64'd65536 : 64'(v);
	endfunction

	function automatic longint unsigned mag_sq(input longint a);
		longint unsigned m;
		m = (a < 0) ? -a : a;
		return m * m;
	endfunction

	function automatic logic [23:0] predict_levels(input logic [IN_W-1:0] d);
		longint          dx, dy, dz, fx, fy, fz, ux, uy, uz, rx, ry, rz;
		longint          nx, ny, nz, dot, p;
		longint unsigned near_d, far_d, ev, src_len, gain, v, rlen;
		logic [7:0]      cv, lft, rgt;
		dx = longint'($signed(d[23:0])) - longint'($signed(lis_x));
		dy = longint'($signed(d[47:24])) - longint'($signed(lis_y));
		dz = longint'($signed(d[71:48])) - longint'($signed(lis_z));
		near_d = d[94:72];
		far_d = d[117:95];
		ev = clip_unity(d[134:118]);
		src_len = int_root(mag_sq(dx) + mag_sq(dy) + mag_sq(dz));
		if (src_len > far_d)
			gain = 0;
		else if (src_len > near_d)
			gain = ((far_d - src_len) << 16) / (far_d - near_d);
		else
			gain = 65536;
		v = (ev * clip_unity(lis_effects)) >> 16;
		v = (v * clip_unity(lis_master)) >> 16;
		v = (v * gain) >> 16;
		cv = v[16:9];

		fx = longint'($signed(lis_fwd[15:0]));
		fy = longint'($signed(lis_fwd[31:16]));
		fz = longint'($signed(lis_fwd[47:32]));
		ux = longint'($signed(lis_up[15:0]));
		uy = longint'($signed(lis_up[31:16]));
		uz = longint'($signed(lis_up[47:32]));
		rx = fy * uz - fz * uy;
		ry = fz * ux - fx * uz;
		rz = fx * uy - fy * ux;
		rlen = int_root(mag_sq(rx) + mag_sq(ry) + mag_sq(rz));
		p = 0;
		if (rlen != 0 && far_d != 0) begin
			nx = (rx * ONE_Q14) / longint'(rlen);
			ny = (ry * ONE_Q14) / longint'(rlen);
			nz = (rz * ONE_Q14) / longint'(rlen);
			dot = dx * nx + dy * ny + dz * nz;
			p = dot / longint'(far_d);
			if (p > ONE_Q14)
				p = ONE_Q14;
			if (p < -ONE_Q14)
				p = -ONE_Q14;
		end
		lft = 8'(((ONE_Q14 - p) * 255) >>> 15);
		rgt = 8'(((ONE_Q14 + p) * 255) >>> 15);
		return {rgt, lft, cv};
	endfunction

	function automatic logic [IN_W-1:0] pack_emitter(input emitter_row_t r);
		return {1'b0, r.vol, r.far_d, r.near_d, r.ez, r.ey, r.ex};
	endfunction

	// mostly emitters placed around the listener inside a modest range,
	// the rest raw random fields
	function automatic logic [IN_W-1:0] random_emitter();
		emitter_row_t r;
		int           span;
		if ($urandom_range(9) < 2) begin
			r.ex = 24'($urandom);
			r.ey = 24'($urandom);
			r.ez = 24'($urandom);
			r.near_d = 23'($urandom);
			r.far_d = 23'($urandom);
			r.vol = 17'($urandom);
		end else begin
			span = ($urandom_range(3) == 0) ? $urandom_range(0, 8388607)
				: $urandom_range(0, 65535);
			r.far_d = 23'(span);
			r.near_d = 23'(($urandom_range(4) == 0) ? $urandom_range(0, 8388607)
				: $urandom_range(0, span));
			r.ex = lis_x + 24'($urandom_range(0, 2 * span) - span);
			r.ey = lis_y + 24'($urandom_range(0, 2 * span) - span);
			r.ez = lis_z + 24'($urandom_range(0, 2 * span) - span);
			r.vol = 17'(($urandom_range(7) == 0) ? $urandom_range(65537, 131071)
				: $urandom_range(0, 65536));
		end
		return pack_emitter(r);
	endfunction

	task automatic send_emitter(input logic [IN_W-1:0] d, input bit known,
			input logic [23:0] levels);
		if ($urandom_range(99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do
			@(posedge clk);
		while (!s_axis_tready);
		level_queue.push_back(known ? levels : predict_levels(d));
	endtask

	// write enable stays high across back-to-back writes; the caller drops it, but a forward or up write drops it itself
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_POS_X:   lis_x = val[23:0];
			REG_POS_Y:   lis_y = val[23:0];
			REG_POS_Z:   lis_z = val[23:0];
			REG_FORWARD: lis_fwd = val;
			REG_UP:      lis_up = val;
			REG_MASTER:  lis_master = val[16:0];
			REG_EFFECTS: lis_effects = val[16:0];
			default: ;
		endcase
		// right vector unit holds the input off after an orientation change
		if (idx == REG_FORWARD || idx == REG_UP) begin
			cfg_we <= 1'b0;
			repeat (200) @(posedge clk);
		end
	endtask

	// receiver: random backpressure plus one long hold-off on request
	initial begin
		int hold;
		int seen;
		hold = 0;
		seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != seen) begin
				seen = hold_req;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	always @(posedge clk) begin
		logic [23:0] want;
		if (m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (level_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, m_axis_tdata);
			end else begin
				want = level_queue.pop_front();
				if (m_axis_tdata[7:0] !== want[7:0]) begin
					errors++;
					$display("%0t: channel_volume expected %0d actual %0d",
						$time, want[7:0], m_axis_tdata[7:0]);
				end
				if (m_axis_tdata[15:8] !== want[15:8]) begin
					errors++;
					$display("%0t: left pan level expected %0d actual %0d",
						$time, want[15:8], m_axis_tdata[15:8]);
				end
				if (m_axis_tdata[23:16] !== want[23:16]) begin
					errors++;
					$display("%0t: right pan level expected %0d actual %0d",
						$time, want[23:16], m_axis_tdata[23:16]);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt > STALL_LIMIT) begin
			$display("tb_spatial_audio_gain_pan_core failed");
			$finish;
		end
	end

	initial begin
		emitter_row_t rows[$];
		logic [47:0]  setup_vals[7];
		logic [47:0]  rnd_vec;
		int           per_setup;
		int           sent;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		errors = 0;
		results_seen = 0;
		stall_cnt = 0;
		hold_req = 0;
		snd_idle = 18;
		rcv_idle = 86;
		lis_x = '0;
		lis_y = '0;
		lis_z = '0;
		lis_fwd = FORWARD_RESET;
		lis_up = UP_RESET;
		lis_master = UNITY;
		lis_effects = UNITY;
		sent = 0;

		// reset listener faces -z with +y up, so the right axis is +x
		rows = '{
			'{0, 0, 0, 256, 1024, 65536, 1, {8'd127, 8'd127, 8'd128}},
			'{0, 0, 0, 0, 0, 65536, 1, {8'd127, 8'd127, 8'd128}},
			'{1024, 0, 0, 256, 1024, 65536, 1, {8'd255, 8'd0, 8'd0}},
			'{-1024, 0, 0, 256, 1024, 65536, 1, {8'd0, 8'd255, 8'd0}},
			'{8388607, 0, 0, 0, 256, 65536, 1, {8'd255, 8'd0, 8'd0}},
			'{-8388608, 0, 0, 0, 256, 65536, 1, {8'd0, 8'd255, 8'd0}},
			'{0, 0, 0, 256, 1024, 131071, 1, {8'd127, 8'd127, 8'd128}},
			'{0, 0, 0, 256, 1024, 0, 1, {8'd127, 8'd127, 8'd0}},
			'{256, 0, 0, 4096, 512, 65536, 0, '0},
			'{600, 0, 0, 4096, 512, 65536, 0, '0},
			'{512, 0, 0, 512, 512, 65536, 0, '0},
			'{300, 400, -200, 100, 2000, 40000, 0, '0},
			'{-700, 8388607, -8388608, 256, 8388607, 65535, 0, '0},
			'{0, -8388608, 8388607, 8388607, 8388607, 65537, 0, '0},
			'{100, 100, 100, 8388607, 0, 1, 0, '0},
			'{-5, 7, 3, 0, 1, 32768, 0, '0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_emitter(pack_emitter(rows[i]), rows[i].known, rows[i].levels);
		s_axis_tvalid <= 1'b0;

		per_setup = RAND_ITEMS / (NUM_SETUPS - 1);
		for (int s = 1; s < NUM_SETUPS; s++) begin
			while (level_queue.size() != 0)
				@(posedge clk);
			rnd_vec = 48'({$urandom, $urandom});
			setup_vals[REG_POS_X]   = 48'($urandom);
			setup_vals[REG_POS_Y]   = 48'($urandom);
			setup_vals[REG_POS_Z]   = 48'($urandom);
			setup_vals[REG_FORWARD] = 48'({$urandom, $urandom});
			setup_vals[REG_UP]      = 48'({$urandom, $urandom});
			setup_vals[REG_MASTER]  = 48'($urandom_range(0, 65536));
			setup_vals[REG_EFFECTS] = 48'($urandom_range(0, 65536));
			case (s)
				1: begin
					// zero forward: no right vector, centered pan
					setup_vals[REG_POS_X] = 48'hFF_FFFF_80_0000;
					setup_vals[REG_POS_Y] = 48'h00_0000_7F_FFFF;
					setup_vals[REG_FORWARD] = '0;
					setup_vals[REG_MASTER] = 48'h1_FFFF;
					setup_vals[REG_EFFECTS] = 48'd65536;
				end
				2: begin
					setup_vals[REG_FORWARD] = {16'd0, 16'd0, 16'sd16384};
					setup_vals[REG_UP] = {16'sd16384, 16'd0, 16'd0};
					setup_vals[REG_MASTER] = 48'd0;
					setup_vals[REG_EFFECTS] = 48'h1_FFFF;
				end
				3: begin
					setup_vals[REG_POS_X] = 48'h00_0000_7F_FFFF;
					setup_vals[REG_POS_Z] = 48'hFF_FFFF_80_0000;
					setup_vals[REG_FORWARD] = ~rnd_vec;
					setup_vals[REG_UP] = rnd_vec;
				end
				4: begin
					// parallel forward and up
					setup_vals[REG_FORWARD] = rnd_vec;
					setup_vals[REG_UP] = rnd_vec;
					setup_vals[REG_MASTER] = 48'd65536;
					setup_vals[REG_EFFECTS] = 48'($urandom_range(0, 131071));
				end
				default: ;
			endcase
			for (int r = 0; r < 7; r++)
				write_reg(CFG_IDX_W'(r), setup_vals[r]);
			cfg_we <= 1'b0;

			for (int n = 0; n < per_setup; n++) begin
				if (sent == RAND_ITEMS / 3) begin
					snd_idle = 86;
					rcv_idle = 18;
					hold_req++;
				end else if (sent == 2 * RAND_ITEMS / 3) begin
					snd_idle = 0;
					rcv_idle = 0;
				end
				send_emitter(random_emitter(), 1'b0, '0);
				sent++;
			end
			s_axis_tvalid <= 1'b0;
		end

		while (level_queue.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("run covered %0d directed and %0d random emitters, %0d results checked,",
			rows.size(), sent, results_seen);
		$display("over %0d listener setups incl. degenerate orientation and gain extremes",
			NUM_SETUPS);
		if (errors == 0)
			$display("tb_spatial_audio_gain_pan_core passed");
		else
			$display("tb_spatial_audio_gain_pan_core failed");
		$finish;
	end

endmodule

`default_nettype wire
